### hw/rtl/bhc_pkg.sv
package bhc_pkg;

    localparam int HDR_LEN = 54;
    localparam int CNT_W = $clog2(HDR_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HDR_LEN - 1);

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW = $clog2(RQ_DEPTH);
    localparam int RQ_CW = $clog2(RQ_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW = $clog2(OQ_DEPTH);
    localparam int OQ_CW = $clog2(OQ_DEPTH + 2);

    localparam int CFG_AW = 4;

    localparam logic [15:0] SIG_BM = 16'h4D42;
    localparam logic [31:0] INFO_CORE = 32'd12;
    localparam logic [31:0] INFO_V1 = 32'd40;
    localparam logic [31:0] INFO_V2 = 32'd52;
    localparam logic [31:0] INFO_V3 = 32'd56;
    localparam logic [31:0] INFO_V4 = 32'd108;
    localparam logic [31:0] INFO_V5 = 32'd124;
    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [36:0] NEED_BASE = 37'd120;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_SIGNATURE = 3'd2,
        ST_INFO_SIZE = 3'd3,
        ST_BPP       = 3'd4,
        ST_COMPRESS  = 3'd5,
        ST_CAPACITY  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        REG_NAME_LEN = 2'd0,
        REG_EXT_LEN  = 2'd1,
        REG_MSG_SIZE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] file_size;
        logic [31:0] pixel_offset;
        logic [31:0] info_size;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  name_length;
        logic [7:0]  extension_length;
        logic [31:0] message_size;
    } t_cfg;

    // raw header fields, little-endian, as captured by the front
    typedef struct packed {
        logic        short_hdr;
        logic [15:0] sig;
        logic [31:0] file_size;
        logic [31:0] pixel_offset;
        logic [31:0] info_size;
        logic [63:0] dims;
        logic [15:0] bpp;
        logic [31:0] compression;
    } t_hdr_rec;

endpackage

### hw/rtl/bhc_cfg.sv
module bhc_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bhc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output bhc_pkg::t_cfg              o_cfg
);

    bhc_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                bhc_pkg::REG_NAME_LEN: begin
                    r_cfg.name_length <= pwdata[7:0];
                end
                bhc_pkg::REG_EXT_LEN: begin
                    r_cfg.extension_length <= pwdata[7:0];
                end
                bhc_pkg::REG_MSG_SIZE: begin
                    r_cfg.message_size <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bhc_pkg::REG_NAME_LEN: prdata = {24'd0, r_cfg.name_length};
            bhc_pkg::REG_EXT_LEN:  prdata = {24'd0, r_cfg.extension_length};
            bhc_pkg::REG_MSG_SIZE: prdata = r_cfg.message_size;
            default:               prdata = '0;
        endcase
    end

endmodule

### hw/rtl/bhc_front.sv
module bhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bhc_pkg::t_in_item   i_item,
    output logic                o_full,
    input  logic                i_rq_full,
    output logic                o_rec_push,
    output bhc_pkg::t_hdr_rec   o_rec
);

    logic [bhc_pkg::CNT_W-1:0] r_count;
    logic                      r_skip;
    logic [15:0]               r_sig;
    logic [31:0]               r_file_size;
    logic [31:0]               r_pix_off;
    logic [31:0]               r_info;
    logic [63:0]               r_dims;
    logic [15:0]               r_bpp;
    logic [31:0]               r_comp;

    logic accept;
    logic at_end;
    logic take;

    assign o_full = i_rq_full;
    assign accept = i_push && !i_rq_full;
    assign at_end = (r_count == bhc_pkg::CNT_LAST);
    assign take   = accept && !r_skip;

    assign o_rec_push = take && (at_end || i_item.last_byte);

    always_comb begin
        o_rec.short_hdr    = !at_end;
        o_rec.sig          = r_sig;
        o_rec.file_size    = r_file_size;
        o_rec.pixel_offset = r_pix_off;
        o_rec.info_size    = r_info;
        o_rec.dims         = r_dims;
        o_rec.bpp          = r_bpp;
        o_rec.compression  = r_comp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_skip  <= 1'b0;
        end else if (accept) begin
            if (r_skip) begin
                if (i_item.last_byte) begin
                    r_skip <= 1'b0;
                end
            end else if (at_end) begin
                r_count <= '0;
                r_skip  <= !i_item.last_byte;
            end else if (i_item.last_byte) begin
                r_count <= '0;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // little-endian fields fill from the top as bytes stream in
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_count inside {[6'd0:6'd1]}) begin
                r_sig <= {i_item.data_byte, r_sig[15:8]};
            end
            if (r_count inside {[6'd2:6'd5]}) begin
                r_file_size <= {i_item.data_byte, r_file_size[31:8]};
            end
            if (r_count inside {[6'd10:6'd13]}) begin
                r_pix_off <= {i_item.data_byte, r_pix_off[31:8]};
            end
            if (r_count inside {[6'd14:6'd17]}) begin
                r_info <= {i_item.data_byte, r_info[31:8]};
            end
            if (r_count inside {[6'd18:6'd25]}) begin
                r_dims <= {i_item.data_byte, r_dims[63:8]};
            end
            if (r_count inside {[6'd28:6'd29]}) begin
                r_bpp <= {i_item.data_byte, r_bpp[15:8]};
            end
            if (r_count inside {[6'd30:6'd33]}) begin
                r_comp <= {i_item.data_byte, r_comp[31:8]};
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bhc_pkg::CNT_LAST)
        else $error("byte counter out of range");

    a_skip_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_count == '0))
        else $error("counter moved while skipping trailing bytes");

    a_end_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && at_end && !i_item.last_byte) |=> r_skip)
        else $error("no skip after full header");

endmodule

### hw/rtl/bhc_rec_queue.sv
module bhc_rec_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bhc_pkg::t_hdr_rec  i_rec,
    input  logic               i_pop,
    output bhc_pkg::t_hdr_rec  o_rec,
    output logic               o_full,
    output logic               o_empty
);

    bhc_pkg::t_hdr_rec          r_mem [bhc_pkg::RQ_DEPTH];
    logic [bhc_pkg::RQ_AW-1:0]  r_wp;
    logic [bhc_pkg::RQ_AW-1:0]  r_rp;
    logic [bhc_pkg::RQ_CW-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == bhc_pkg::RQ_CW'(bhc_pkg::RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/bhc_back.sv
module bhc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bhc_pkg::t_cfg      i_cfg,
    input  bhc_pkg::t_hdr_rec  i_rec,
    input  logic               i_rq_empty,
    output logic               o_rq_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output bhc_pkg::t_out_item o_result
);

    bhc_pkg::t_out_item         r_s1;
    logic                       r_v1;
    logic                       r_s1_cap;
    logic [63:0]                r_s1_prod;
    logic [36:0]                r_s1_need;

    bhc_pkg::t_out_item         r_oq [bhc_pkg::OQ_DEPTH];
    logic [bhc_pkg::OQ_AW-1:0]  r_wp;
    logic [bhc_pkg::OQ_AW-1:0]  r_rp;
    logic [bhc_pkg::OQ_CW-1:0]  r_cnt;

    bhc_pkg::t_out_item n_s1;
    logic               n_cap;
    logic [63:0]        n_prod;
    logic [36:0]        n_need;
    logic [32:0]        len_sum;
    logic               core;
    logic               info_ok;
    logic [31:0]        w;
    logic [31:0]        h;
    logic [31:0]        h_raw;
    logic [15:0]        bpp;
    logic               issue;
    logic               do_pop;
    logic [42:0]        cap3;
    logic               roomy;
    bhc_pkg::t_out_item fin;

    // stage 1: classify header and form width * height
    always_comb begin
        core    = (i_rec.info_size == bhc_pkg::INFO_CORE);
        info_ok = i_rec.info_size inside {bhc_pkg::INFO_CORE, bhc_pkg::INFO_V1,
            bhc_pkg::INFO_V2, bhc_pkg::INFO_V3, bhc_pkg::INFO_V4, bhc_pkg::INFO_V5};
        h_raw = i_rec.dims[63:32];
        if (core) begin
            w   = {16'd0, i_rec.dims[15:0]};
            h   = {16'd0, i_rec.dims[31:16]};
            bpp = i_rec.dims[63:48];
        end else begin
            w   = i_rec.dims[31:0];
            h   = h_raw[31] ? (32'd0 - h_raw) : h_raw;
            bpp = i_rec.bpp;
        end

        n_s1        = '0;
        n_s1.status = bhc_pkg::ST_OK;
        n_cap       = 1'b0;
        if (i_rec.short_hdr) begin
            n_s1.status = bhc_pkg::ST_SHORT;
        end else if (i_rec.sig != bhc_pkg::SIG_BM) begin
            n_s1.status = bhc_pkg::ST_SIGNATURE;
        end else begin
            n_s1.file_size    = i_rec.file_size;
            n_s1.pixel_offset = i_rec.pixel_offset;
            n_s1.info_size    = i_rec.info_size;
            if (!info_ok) begin
                n_s1.status = bhc_pkg::ST_INFO_SIZE;
            end else begin
                n_s1.image_width  = w;
                n_s1.image_height = h;
                if (bpp != bhc_pkg::BPP_24) begin
                    n_s1.status = bhc_pkg::ST_BPP;
                end else if (!core && (i_rec.compression != '0)) begin
                    n_s1.status = bhc_pkg::ST_COMPRESS;
                end else begin
                    n_cap = 1'b1;
                end
            end
        end
    end

    assign n_prod  = w * h;
    assign len_sum = {25'd0, i_cfg.name_length} + {25'd0, i_cfg.extension_length}
                   + {1'b0, i_cfg.message_size};
    assign n_need  = {1'b0, len_sum, 3'b000} + bhc_pkg::NEED_BASE;

    // keep room in the result queue for everything in flight
    assign issue    = !i_rq_empty
                   && ((r_cnt + bhc_pkg::OQ_CW'(r_v1)) < bhc_pkg::OQ_CW'(bhc_pkg::OQ_DEPTH));
    assign o_rq_pop = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1      <= n_s1;
            r_s1_cap  <= n_cap;
            r_s1_prod <= n_prod;
            r_s1_need <= n_need;
        end
    end

    // stage 2: capacity compare, then into the result queue
    assign cap3  = {2'b00, r_s1_prod[40:0]} + {1'b0, r_s1_prod[40:0], 1'b0};
    assign roomy = (|r_s1_prod[63:41]) || ({6'd0, r_s1_need} <= cap3);

    always_comb begin
        fin = r_s1;
        if (r_s1_cap) begin
            fin.status = roomy ? bhc_pkg::ST_OK : bhc_pkg::ST_CAPACITY;
        end
    end

    assign o_empty  = (r_cnt == '0);
    assign do_pop   = i_pop && !o_empty;
    assign o_result = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_oq[r_wp] <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_v1) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (r_v1 && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !r_v1) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= bhc_pkg::OQ_CW'(bhc_pkg::OQ_DEPTH))
        else $error("result queue count overflow");

    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_cnt < bhc_pkg::OQ_CW'(bhc_pkg::OQ_DEPTH)))
        else $error("result written into full queue");

    a_cap_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_s1_cap) |-> (r_s1.status == bhc_pkg::ST_OK))
        else $error("capacity check on a failed header");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_s1.status == bhc_pkg::ST_SHORT)
            |-> (r_s1.file_size == '0 && r_s1.image_width == '0
                 && r_s1.image_height == '0))
        else $error("short header result carries fields");

endmodule

### hw/rtl/bmp_header_check.sv
// bmp header check: takes a bmp file one byte per transfer and reports its header
// input queue side: push/full with i_item (data byte and last-byte flag); one
//   byte is taken every cycle while full is low
// result queue side: empty/pop with o_result; one result per file, either at
//   header byte 54 or at an early last byte (short header)
// configuration: apb-style writes of name length (0x0), extension length (0x4)
//   and message size (0x8) feed the capacity check; pready is tied high
// path: a result reaches o_result through the header queue, the stage 1 register
//   and the result queue, where empty then falls; the back holds it while the result queue has no room
// throughput: one byte per cycle while full is low, and one result per cycle for
//   back-to-back one-byte files while pop keeps up; the front fills a four-entry header queue and the back
//   runs a one-multiplier stage ahead of a four-entry result queue
// if pop stays low the result queue fills, the back stops pulling headers and,
//   once the header queue fills too, full rises until results are taken;
//   bytes that produce no result still need the header queue not full
// reset (synchronous, active low) empties both queues, re-arms the byte
//   counter and clears the configuration registers
module bmp_header_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  bhc_pkg::t_in_item          i_item,
    output logic                       empty,
    input  logic                       pop,
    output bhc_pkg::t_out_item         o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bhc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    bhc_pkg::t_cfg     cfg;
    bhc_pkg::t_hdr_rec rec_in;
    bhc_pkg::t_hdr_rec rec_out;
    logic              rec_push;
    logic              rq_full;
    logic              rq_empty;
    logic              rq_pop;

    bhc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bhc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_rq_full  (rq_full),
        .o_rec_push (rec_push),
        .o_rec      (rec_in)
    );

    bhc_rec_queue u_rec_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .i_pop   (rq_pop),
        .o_rec   (rec_out),
        .o_full  (rq_full),
        .o_empty (rq_empty)
    );

    bhc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_rec      (rec_out),
        .i_rq_empty (rq_empty),
        .o_rq_pop   (rq_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

endmodule

### tb/sv/bmp_header_check_test.sv
module bmp_header_check_test;
    import bhc_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 1000;
    localparam int PHASE_BYTES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in_item i_item = '0;
    logic empty;
    logic pop = 1'b0;
    t_out_item o_result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bmp_header_check u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // header predictor state
    logic [7:0] hdr_copy [HDR_LEN];
    int byte_cnt = 0;
    bit skipping = 1'b0;
    logic [7:0] cfg_name = '0;
    logic [7:0] cfg_ext = '0;
    logic [31:0] cfg_msg = '0;

    t_in_item file_bytes [$];
    t_out_item reports_due [$];
    logic [7:0] file_hdr [HDR_LEN];

    int errors = 0;
    int files_sent = 0;
    int header_bytes = 0;
    int reports_done = 0;
    int settings_used = 0;
    int status_count [8];
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int pop_mode = 0;
    int mode_cycles = 0;
    int idle_cycles = 0;
    t_out_item want;

    function automatic logic [31:0] hdr16(int at);
        return {16'h0, hdr_copy[at + 1], hdr_copy[at]};
    endfunction

    function automatic logic [31:0] hdr32(int at);
        return {hdr_copy[at + 3], hdr_copy[at + 2], hdr_copy[at + 1], hdr_copy[at]};
    endfunction

    function automatic t_out_item eval_header();
        t_out_item r;
        logic [31:0] info;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] bpp;
        logic [67:0] need;
        logic [67:0] room;
        r = '0;
        if ({hdr_copy[1], hdr_copy[0]} != SIG_BM) begin
            r.status = ST_SIGNATURE;
            return r;
        end
        info = hdr32(14);
        r.file_size = hdr32(2);
        r.pixel_offset = hdr32(10);
        r.info_size = info;
        if (info != INFO_CORE && info != INFO_V1 && info != INFO_V2 && info != INFO_V3 &&
            info != INFO_V4 && info != INFO_V5) begin
            r.status = ST_INFO_SIZE;
            return r;
        end
        if (info == INFO_CORE) begin
            w = hdr16(18);
            h = hdr16(20);
            bpp = hdr16(24);
        end else begin
            w = hdr32(18);
            h = hdr32(22);
            if (h[31])
                h = -h;
            bpp = hdr16(28);
        end
        r.image_width = w;
        r.image_height = h;
        if (bpp != 32'(BPP_24)) begin
            r.status = ST_BPP;
            return r;
        end
        if (info != INFO_CORE && hdr32(30) != 32'd0) begin
            r.status = ST_COMPRESS;
            return r;
        end
        need = 68'd120 + 68'd8 * (68'(cfg_name) + 68'(cfg_ext) + 68'(cfg_msg));
        room = 68'(w) * 68'(h) * 68'd3;
        r.status = (need <= room) ? ST_OK : ST_CAPACITY;
        return r;
    endfunction

    task automatic add_report(t_out_item r);
        reports_due.push_back(r);
        status_count[r.status]++;
    endtask

    task automatic predict_byte(t_in_item it);
        t_out_item r;
        if (skipping) begin
            if (it.last_byte) begin
                byte_cnt = 0;
                skipping = 1'b0;
            end
            return;
        end
        hdr_copy[byte_cnt] = it.data_byte;
        byte_cnt++;
        if (byte_cnt >= HDR_LEN) begin
            add_report(eval_header());
            if (it.last_byte)
                byte_cnt = 0;
            else
                skipping = 1'b1;
        end else if (it.last_byte) begin
            r = '0;
            r.status = ST_SHORT;
            add_report(r);
            byte_cnt = 0;
        end
    endtask

    task automatic check_field(string what, logic [31:0] exp_val, logic [31:0] got);
        if (exp_val !== got) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, what, exp_val, got);
        end
    endtask

    // input side: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_byte(file_bytes.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    burst_left = $urandom_range(1, 40);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (file_bytes.size() > 0) begin
                push <= 1'b1;
                i_item <= file_bytes[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side: checks each transfer and stalls on its own pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                reports_done++;
                if (reports_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h", $time, o_result);
                end else begin
                    want = reports_due.pop_front();
                    check_field("status", 32'(want.status), 32'(o_result.status));
                    check_field("file_size", want.file_size, o_result.file_size);
                    check_field("pixel_offset", want.pixel_offset, o_result.pixel_offset);
                    check_field("info_size", want.info_size, o_result.info_size);
                    check_field("image_width", want.image_width, o_result.image_width);
                    check_field("image_height", want.image_height, o_result.image_height);
                end
            end
            mode_cycles++;
            if (mode_cycles >= 50) begin
                mode_cycles = 0;
                pop_mode = $urandom_range(0, 2);
            end
            if (!hold_done && reports_done >= 3) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (pop_mode)
                    0: begin
                        pop <= 1'b1;
                    end
                    1: begin
                        pop <= $urandom_range(0, 1);
                    end
                    default: begin
                        pop <= ($urandom_range(0, 5) == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] name_len, logic [7:0] ext_len, logic [31:0] msg_size);
        write_reg(REG_NAME_LEN, 32'(name_len));
        write_reg(REG_EXT_LEN, 32'(ext_len));
        write_reg(REG_MSG_SIZE, msg_size);
        cfg_name = name_len;
        cfg_ext = ext_len;
        cfg_msg = msg_size;
        settings_used++;
    endtask

    task automatic wait_drain();
        while (file_bytes.size() != 0 || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_le(int at, int nbytes, logic [31:0] value);
        for (int k = 0; k < nbytes; k++)
            file_hdr[at + k] = value[8 * k +: 8];
    endtask

    task automatic send_file(int len);
        t_in_item it;
        for (int k = 0; k < len; k++) begin
            it.data_byte = (k < HDR_LEN) ? file_hdr[k] : 8'($urandom);
            it.last_byte = (k == len - 1);
            file_bytes.push_back(it);
        end
        files_sent++;
        header_bytes += (len < HDR_LEN) ? len : HDR_LEN;
    endtask

    task automatic fill_file(logic [7:0] value, int len);
        for (int k = 0; k < HDR_LEN; k++)
            file_hdr[k] = value;
        send_file(len);
    endtask

    task automatic queue_file(logic [15:0] sig, logic [31:0] info, logic [31:0] w,
                              logic [31:0] h, logic [15:0] bpp, logic [31:0] comp, int len);
        for (int k = 0; k < HDR_LEN; k++)
            file_hdr[k] = 8'($urandom);
        put_le(0, 2, 32'(sig));
        put_le(14, 4, info);
        put_le(30, 4, comp);
        if (info == INFO_CORE) begin
            put_le(18, 2, w);
            put_le(20, 2, h);
            put_le(24, 2, 32'(bpp));
        end else begin
            put_le(18, 4, w);
            put_le(22, 4, h);
            put_le(28, 2, 32'(bpp));
        end
        send_file(len);
    endtask

    task automatic random_file();
        logic [15:0] sig;
        logic [31:0] info;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bpp;
        logic [31:0] comp;
        int len;
        sig = ($urandom_range(0, 9) == 0) ? 16'($urandom) : SIG_BM;
        case ($urandom_range(0, 7))
            0: info = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 130));
            1: info = INFO_CORE;
            2: info = INFO_V1;
            3: info = INFO_V2;
            4: info = INFO_V3;
            5: info = INFO_V4;
            default: info = INFO_V5;
        endcase
        case ($urandom_range(0, 2))
            0: begin
                w = $urandom_range(0, 64);
                h = $urandom_range(0, 64);
            end
            1: begin
                w = $urandom;
                h = $urandom;
            end
            default: begin
                w = $urandom_range(0, 70000);
                h = $urandom_range(0, 1) ? -32'($urandom_range(0, 70000))
                                         : 32'($urandom_range(0, 70000));
            end
        endcase
        bpp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : BPP_24;
        comp = ($urandom_range(0, 7) == 0) ? $urandom : 32'd0;
        if ($urandom_range(0, 1) == 0)
            len = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 53);
        else
            len = HDR_LEN + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
        queue_file(sig, info, w, h, bpp, comp, len);
    endtask

    task automatic random_phase();
        int start_bytes;
        int start_files;
        start_bytes = header_bytes;
        start_files = files_sent;
        while (header_bytes - start_bytes < PHASE_BYTES || files_sent - start_files < 2)
            random_file();
        wait_drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(8'd0, 8'd0, 32'd0);

        fill_file(8'hFF, 1);
        fill_file(8'hFF, 53);
        fill_file(8'h00, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'd40, 32'd1, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'd39, 32'd1, BPP_24, 32'd0, HDR_LEN + 3);
        queue_file(16'h4E42, INFO_V1, 32'd10, 32'd10, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, 32'd41, 32'd10, 32'd10, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, 32'hFFFF_FFFF, 32'd10, 32'd10, BPP_24, 32'd0, HDR_LEN + 1);
        queue_file(SIG_BM, INFO_CORE, 32'hFFFF, 32'hFFFF, BPP_24, 32'hFFFF_FFFF, HDR_LEN);
        queue_file(SIG_BM, INFO_CORE, 32'd100, 32'd100, 16'd32, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V2, 32'd100, 32'd100, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V3, 32'd100, 32'd100, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V4, 32'd100, 32'd100, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V5, 32'd100, 32'd100, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'd100, 32'd100, 16'hFFFF, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'd100, 32'd100, BPP_24, 32'd1, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'd100, -32'd256, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'd1, 32'h8000_0000, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'd0, 32'd100, BPP_24, 32'd0, HDR_LEN);
        queue_file(SIG_BM, INFO_V1, 32'd100, 32'd0, BPP_24, 32'd0, HDR_LEN + 2);
        wait_drain();

        set_config(8'hFF, 8'hFF, 32'hFFFF_FFFF);
        random_phase();
        set_config(8'($urandom), 8'($urandom), 32'($urandom_range(0, 3000)));
        random_phase();
        set_config(8'($urandom), 8'($urandom), $urandom);
        random_phase();
        set_config(8'd0, 8'd0, 32'd0);
        random_phase();

        $display("%0d files, %0d header bytes, %0d reports checked, %0d register settings",
                 files_sent, header_bytes, reports_done, settings_used);
        $display("reports by status ok/short/sig/info/bpp/comp/cap: %0d %0d %0d %0d %0d %0d %0d",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 status_count[4], status_count[5], status_count[6]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/bhc_pkg.sv
hw/rtl/bhc_cfg.sv
hw/rtl/bhc_front.sv
hw/rtl/bhc_rec_queue.sv
hw/rtl/bhc_back.sv
hw/rtl/bmp_header_check.sv
tb/sv/bmp_header_check_test.sv
